// ----- rtl/lgdw_pkg.sv -----
`default_nettype none

package lgdw_pkg;

	// Window and best lengths saturate at the top of this width
	localparam int unsigned WIN_BITS = 11;

	typedef logic [WIN_BITS-1:0] win_t;

	localparam win_t WIN_MAX = '1;

	// Window state after one symbol
	typedef struct packed {
		win_t window;
		win_t best;
	} win_state_t;

endpackage

`default_nettype wire

// ----- rtl/longest_distinct_window_top.sv -----
// Longest repeat-free window over a symbol stream.
// Stage 1 registers the table read, the result register the update; throughput is one symbol
// per cycle unless the result stalls; table read and write forward across adjacent symbols.
// Reset: asynchronous, active low; afterwards a clearing sweep writes every table entry,
// 2^SYMBOL_BITS entries (1024 by default), with in_ready held low.
`default_nettype none

module longest_distinct_window_top #(
	parameter int unsigned SYMBOL_BITS = 10,
	parameter int unsigned POS_BITS    = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output      logic        in_ready,
	input  wire logic [9:0]  symbol,
	input  wire logic        new_sequence,
	output      logic        out_valid,
	input  wire logic        out_ready,
	output      logic [10:0] window_length,
	output      logic [10:0] best_length
);

	localparam int unsigned DEPTH = 2 ** SYMBOL_BITS;
	localparam int unsigned ENTRY_BITS = POS_BITS + 1;

	logic                   in_accept;
	logic                   adv;
	logic [SYMBOL_BITS-1:0] idx_in;

	logic                   clearing_q;
	logic [SYMBOL_BITS-1:0] clr_addr_q;

	logic                   valid_s1;
	logic                   new_seq_s1;
	logic [SYMBOL_BITS-1:0] idx_s1;
	logic                   fwd_s1;
	logic [ENTRY_BITS-1:0]  fwd_data_s1;

	logic [POS_BITS-1:0]    pos_q;
	lgdw_pkg::win_state_t   win_q;
	lgdw_pkg::win_state_t   win_nxt;

	logic                   out_valid_q;
	lgdw_pkg::win_t         window_length_q;
	lgdw_pkg::win_t         best_length_q;

	logic                   ram_we;
	logic [SYMBOL_BITS-1:0] ram_waddr;
	logic [ENTRY_BITS-1:0]  ram_wdata;
	logic [ENTRY_BITS-1:0]  ram_rdata;
	logic [ENTRY_BITS-1:0]  entry;
	logic [ENTRY_BITS-1:0]  new_entry;

	// Handshake
	assign adv       = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !clearing_q && (!valid_s1 || adv);
	assign in_accept = in_valid && in_ready;
	assign idx_in    = SYMBOL_BITS'(symbol);

	// Table write: clearing sweep, else the symbol leaving stage 1
	assign new_entry = {1'b1, pos_q};
	assign ram_we    = clearing_q || adv;
	assign ram_waddr = clearing_q ? clr_addr_q : idx_s1;
	assign ram_wdata = clearing_q ? '0 : new_entry;

	lgdw_ram #(
		.WIDTH(ENTRY_BITS),
		.DEPTH(DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (in_accept),
		.raddr(idx_in),
		.rdata(ram_rdata)
	);

	// Forward the write that lands on the same edge as the read
	assign entry = fwd_s1 ? fwd_data_s1 : ram_rdata;

	lgdw_update #(
		.POS_BITS(POS_BITS)
	) u_update (
		.new_seq (new_seq_s1),
		.seen    (entry[POS_BITS]),
		.last_pos(entry[POS_BITS-1:0]),
		.pos     (pos_q),
		.cur     (win_q),
		.nxt     (win_nxt)
	);

	// Clearing sweep after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + SYMBOL_BITS'(1);
			if (&clr_addr_q) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// Stage 1 payload and forwarding capture
	always_ff @(posedge clk) begin
		if (in_accept) begin
			new_seq_s1  <= new_sequence;
			idx_s1      <= idx_in;
			fwd_s1      <= adv && (idx_s1 == idx_in);
			fwd_data_s1 <= new_entry;
		end
	end

	// Window state and position advance with each symbol
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			win_q <= '0;
		end else if (adv) begin
			pos_q <= pos_q + POS_BITS'(1);
			win_q <= win_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			window_length_q <= win_nxt.window;
			best_length_q   <= win_nxt.best;
		end
	end

	assign out_valid     = out_valid_q;
	assign window_length = window_length_q;
	assign best_length   = best_length_q;

endmodule

`default_nettype wire

// ----- rtl/lgdw_ram.sv -----
`default_nettype none

module lgdw_ram #(
	parameter int unsigned WIDTH = 33,
	parameter int unsigned DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read, returns the old data on a same-address write
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/lgdw_update.sv -----
`default_nettype none

module lgdw_update #(
	parameter int unsigned POS_BITS = 32
) (
	input  wire logic                  new_seq,
	input  wire logic                  seen,
	input  wire logic [POS_BITS-1:0]   last_pos,
	input  wire logic [POS_BITS-1:0]   pos,
	input  wire lgdw_pkg::win_state_t  cur,
	output      lgdw_pkg::win_state_t  nxt
);

	lgdw_pkg::win_t        win_base;
	lgdw_pkg::win_t        best_base;
	logic [POS_BITS-1:0]   pos_gap;
	logic                  shrink;

	// Drop window and best at the start of a sequence
	assign win_base  = new_seq ? '0 : cur.window;
	assign best_base = new_seq ? '0 : cur.best;

	// Shrink to just after the earlier occurrence when it lies in the window
	assign pos_gap = pos - last_pos;
	assign shrink  = seen && (pos_gap != '0) && (pos_gap <= POS_BITS'(win_base));

	always_comb begin
		if (shrink) begin
			nxt.window = lgdw_pkg::WIN_BITS'(pos_gap);
		end else if (win_base != lgdw_pkg::WIN_MAX) begin
			nxt.window = win_base + lgdw_pkg::WIN_BITS'(1);
		end else begin
			nxt.window = win_base;
		end
		nxt.best = (nxt.window > best_base) ? nxt.window : best_base;
	end

endmodule

`default_nettype wire

// ----- rtl/lgdw_checker.sv -----
`default_nettype none

module lgdw_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [10:0] window_length,
	input wire logic [10:0] best_length
);

	// Hold a stalled result transaction
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(window_length) && $stable(best_length))
		else $error("result changed while stalled");

	// Best never trails the current window
	a_best_ge_window: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> best_length >= window_length)
		else $error("best length below window length");

	// Every window holds at least the current symbol
	a_window_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> window_length != 11'd0)
		else $error("empty window reported");

endmodule

bind longest_distinct_window_top lgdw_checker u_lgdw_checker (.*);

`default_nettype wire
